// ===== hdl/rlpf_pkg.sv =====
// Shared types, constants and configuration defaults for the RGB LED PWM flash controller.
package rlpf_pkg;

  // Channel count and top PWM level
  localparam int CHANNELS  = 3;
  localparam int LEVEL_MAX = 19;

  // Channel assignment of the two flash patterns
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;

  // PWM counter runs 0..LEVEL_MAX+1
  localparam int CNT_W = $clog2(LEVEL_MAX + 2);
  // Pin vector padded so the three LED pins always exist
  localparam int PIN_W = (CHANNELS > 3) ? CHANNELS : 3;

  // Phase time width and saturation value
  localparam int TIME_W   = 18;
  localparam int TIME_SAT = (1 << TIME_W) - 1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] ptime_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FLASH_LEVEL   = 3'd0,
    CFG_FLASH_COUNT   = 3'd1,
    CFG_ON_TIME_MS    = 3'd2,
    CFG_OFF_TIME_MS   = 3'd3,
    CFG_GAP_NORMAL_MS = 3'd4,
    CFG_GAP_ERROR_MS  = 3'd5,
    CFG_TASK_PERIOD   = 3'd6
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [4:0]  RST_FLASH_LEVEL   = 5'd19;
  localparam logic [7:0]  RST_FLASH_COUNT   = 8'd1;
  localparam logic [15:0] RST_ON_TIME_MS    = 16'd100;
  localparam logic [15:0] RST_OFF_TIME_MS   = 16'd100;
  localparam logic [15:0] RST_GAP_NORMAL_MS = 16'd2500;
  localparam logic [15:0] RST_GAP_ERROR_MS  = 16'd500;
  localparam logic [7:0]  RST_TASK_PERIOD   = 8'd50;

  // Current configuration as seen by the pattern core
  typedef struct packed {
    logic [4:0]  flash_level;
    logic [7:0]  flash_count;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [15:0] gap_normal_ms;
    logic [15:0] gap_error_ms;
    logic [7:0]  task_period;
  } rlpf_cfg_t;

  // One result item
  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic pattern_done;
  } rlpf_res_t;

  // Core status toward the top level
  typedef struct packed {
    logic task_step;
    logic mode_clear;
  } rlpf_stat_t;

endpackage

// ===== hdl/rlpf_cfg.sv =====
// Configuration register file of the RGB LED PWM flash controller.
module rlpf_cfg
  import rlpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output rlpf_cfg_t   cfg
);

  rlpf_cfg_t cfg_r;
  rlpf_cfg_t cfg_nxt;

  // Decode the write into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_FLASH_LEVEL:   cfg_nxt.flash_level   = wr_data[4:0];
        CFG_FLASH_COUNT:   cfg_nxt.flash_count   = wr_data[7:0];
        CFG_ON_TIME_MS:    cfg_nxt.on_time_ms    = wr_data;
        CFG_OFF_TIME_MS:   cfg_nxt.off_time_ms   = wr_data;
        CFG_GAP_NORMAL_MS: cfg_nxt.gap_normal_ms = wr_data;
        CFG_GAP_ERROR_MS:  cfg_nxt.gap_error_ms  = wr_data;
        CFG_TASK_PERIOD:   cfg_nxt.task_period   = wr_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers, load defaults on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_level   <= RST_FLASH_LEVEL;
      cfg_r.flash_count   <= RST_FLASH_COUNT;
      cfg_r.on_time_ms    <= RST_ON_TIME_MS;
      cfg_r.off_time_ms   <= RST_OFF_TIME_MS;
      cfg_r.gap_normal_ms <= RST_GAP_NORMAL_MS;
      cfg_r.gap_error_ms  <= RST_GAP_ERROR_MS;
      cfg_r.task_period   <= RST_TASK_PERIOD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/rlpf_core.sv =====
// Pattern state and per-tick update logic: PWM counters, task divider, flash sequencer.
module rlpf_core
  import rlpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       error_flag,
  input  rlpf_cfg_t  cfg,
  output rlpf_res_t  res,
  output rlpf_stat_t stat
);

  cnt_t        pwm_r      [CHANNELS];
  cnt_t        pwm_nxt    [CHANNELS];
  cnt_t        level_r    [CHANNELS];
  cnt_t        level_nxt  [CHANNELS];
  ptime_t      phase_r    [CHANNELS];
  ptime_t      phase_nxt  [CHANNELS];
  logic [7:0]  flashes_r  [CHANNELS];
  logic [7:0]  flashes_nxt[CHANNELS];
  logic [7:0]  tick_r;
  logic [7:0]  tick_nxt;
  logic        cur_mode_r;
  logic        cur_mode_nxt;
  logic        prev_mode_r;
  logic        prev_mode_nxt;

  logic [PIN_W-1:0] pins;
  logic             task_w;
  logic             clr;
  logic             done;
  logic [7:0]       eff_period;
  cnt_t             lvl_sat;
  logic [15:0]      gap;
  logic [16:0]      on_off;
  logic [8:0]       tick_sum;

  // Task period zero acts as one
  assign eff_period = (cfg.task_period == 8'd0) ? 8'd1 : cfg.task_period;
  assign lvl_sat    = (int'(cfg.flash_level) > LEVEL_MAX) ? cnt_t'(LEVEL_MAX)
                                                           : cnt_t'(cfg.flash_level);
  assign gap        = error_flag ? cfg.gap_error_ms : cfg.gap_normal_ms;
  assign on_off     = {1'b0, cfg.on_time_ms} + {1'b0, cfg.off_time_ms};
  assign task_w     = (tick_r == 8'd0);
  assign clr        = task_w && (cur_mode_r != prev_mode_r);
  assign tick_sum   = {1'b0, tick_r} + 9'd1;

  // Advance every channel: pins from the old levels, then the task step
  always_comb begin
    cnt_t                lvl_b;
    ptime_t              t;
    logic [7:0]          fd;
    logic [TIME_W:0]     t_sum;
    logic                is_tgt;
    pins = '0;
    done = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      pins[i]    = (pwm_r[i] < level_r[i]);
      pwm_nxt[i] = (int'(pwm_r[i]) > LEVEL_MAX) ? '0 : pwm_r[i] + cnt_t'(1);

      lvl_b  = clr ? '0 : level_r[i];
      t      = clr ? '0 : phase_r[i];
      fd     = clr ? '0 : flashes_r[i];
      is_tgt = error_flag ? (i == CH_RED) : (i == CH_GREEN);

      if (is_tgt) begin
        if (fd < cfg.flash_count) begin
          if (t < {{(TIME_W-16){1'b0}}, cfg.on_time_ms}) begin
            lvl_b = lvl_sat;
          end else if (t < {{(TIME_W-17){1'b0}}, on_off}) begin
            lvl_b = '0;
          end else begin
            t  = '0;
            fd = fd + 8'd1;
          end
        end else begin
          if (t < {{(TIME_W-16){1'b0}}, gap}) begin
            lvl_b = '0;
          end else begin
            t    = '0;
            fd   = '0;
            done = task_w;
          end
        end
        // Add elapsed time, saturate
        t_sum = {1'b0, t} + (TIME_W+1)'(eff_period);
        t     = (t_sum > (TIME_W+1)'(TIME_SAT)) ? ptime_t'(TIME_SAT) : t_sum[TIME_W-1:0];
      end else begin
        t_sum = '0;
        lvl_b = '0;
      end

      level_nxt[i]   = task_w ? lvl_b : level_r[i];
      phase_nxt[i]   = task_w ? t     : phase_r[i];
      flashes_nxt[i] = task_w ? fd    : flashes_r[i];
    end
  end

  // Mode tracking and task divider
  always_comb begin
    prev_mode_nxt = clr ? cur_mode_r : prev_mode_r;
    cur_mode_nxt  = task_w ? error_flag : cur_mode_r;
    tick_nxt      = (tick_sum >= {1'b0, eff_period}) ? 8'd0 : tick_sum[7:0];
  end

  // Commit the state when an item passes through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pwm_r[i]     <= '0;
        level_r[i]   <= '0;
        phase_r[i]   <= '0;
        flashes_r[i] <= '0;
      end
      tick_r      <= '0;
      cur_mode_r  <= 1'b0;
      prev_mode_r <= 1'b0;
    end else if (step) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pwm_r[i]     <= pwm_nxt[i];
        level_r[i]   <= level_nxt[i];
        phase_r[i]   <= phase_nxt[i];
        flashes_r[i] <= flashes_nxt[i];
      end
      tick_r      <= tick_nxt;
      cur_mode_r  <= cur_mode_nxt;
      prev_mode_r <= prev_mode_nxt;
    end
  end

  assign res.red_on       = pins[0];
  assign res.green_on     = pins[1];
  assign res.blue_on      = pins[2];
  assign res.pattern_done = done;

  assign stat.task_step  = task_w;
  assign stat.mode_clear = clr;

endmodule

// ===== hdl/rgb_led_pwm_flash_controller.sv =====
// Top level of the RGB LED PWM flash controller: handshake, input and result registers.
// One input item is one 1 ms tick and yields one result item. The block takes one item per
// clock cycle while in_stall is low: an item sits in the input register while the PWM
// compares, the task divider and the flash sequencer (a handful of counter adds and
// compares) update. Its result is loaded into the result register when that register is
// free or being drained, and out_valid rises with the load. While out_stall is high the
// result register holds its item and the input register can take one more; in_stall rises
// once both are full. Configuration writes are taken in every cycle (cfg_ready is always
// high) and apply to every item that leaves the input register after the write, so write
// only while no item is in flight. Pins show the levels from before the tick's own task
// step; pattern_done is set only on ticks that run a task step and end a gap.
module rgb_led_pwm_flash_controller
  import rlpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_error_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_red_on,
  output logic        out_green_on,
  output logic        out_blue_on,
  output logic        out_pattern_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rlpf_cfg_t  cfg;
  rlpf_res_t  res;
  rlpf_stat_t stat;

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  logic      s1_flag_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  rlpf_res_t out_r;
  logic      advance;
  logic      in_acc;

  // Configuration registers
  assign cfg_ready = 1'b1;

  rlpf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pattern core
  rlpf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .error_flag (s1_flag_r),
    .cfg        (cfg),
    .res        (res),
    .stat       (stat)
  );

  // Move the item forward when the result register is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flag_r <= in_error_flag;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_on       = out_r.red_on;
  assign out_green_on     = out_r.green_on;
  assign out_blue_on      = out_r.blue_on;
  assign out_pattern_done = out_r.pattern_done;

`ifndef SYNTHESIS
  // Accepted item lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item missing from input register");

  // A held item keeps its flag
  a_hold_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_flag_r)))
    else $error("held item lost or changed");

  // pattern_done only on task steps
  a_done_task: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !stat.task_step) |=> !out_pattern_done)
    else $error("pattern_done without task step");

  // Mode clear only happens in a task step
  a_clear_task: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mode_clear |-> stat.task_step)
    else $error("mode clear outside task step");
`endif

endmodule

// ===== tb/sv/rgb_led_pwm_flash_controller_test.sv =====
// Self-checking testbench for the RGB LED PWM flash controller: directed table, random phases.
`timescale 1ns / 1ps

module rgb_led_pwm_flash_controller_test;
  import rlpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TAIL_CYCLES = 10;
  localparam int PHASES = 9;
  localparam int PHASE_TICKS = 78;
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

  // Row kinds of the directed table
  localparam logic ROW_TICK = 1'b0;
  localparam logic ROW_CFG  = 1'b1;

  // Value styles for random register settings
  localparam int STYLE_RANDOM = 0;
  localparam int STYLE_MIN    = 1;
  localparam int STYLE_MAX    = 2;

  localparam rlpf_res_t PINS_DARK = '0;
  localparam rlpf_res_t PINS_GREEN =
    '{red_on: 1'b0, green_on: 1'b1, blue_on: 1'b0, pattern_done: 1'b0};

  typedef struct packed {
    logic       kind;
    logic [2:0] idx;
    logic [15:0] data;
    logic       flag;
    logic       typed;
    rlpf_res_t  res;
  } dir_row_t;

  // Directed part: reset state, period lowered mid-count, mode change, saturated level,
  // zero flash count, zero period, ignored register index, masked upper data bits
  localparam dir_row_t DIRECTED_ROWS [28] = '{
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b1, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b1, PINS_GREEN},
    '{ROW_CFG, CFG_TASK_PERIOD, 16'h0001, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b1, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b1, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b1, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_FLASH_LEVEL, 16'hFFFF, 1'b0, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_ON_TIME_MS, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_OFF_TIME_MS, 16'hFFFF, 1'b0, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_GAP_ERROR_MS, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_FLASH_COUNT, 16'hFF00, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b1, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b1, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b1, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_TASK_PERIOD, 16'hFF00, 1'b0, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_UNUSED_IDX, 16'hFFFF, 1'b0, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_GAP_NORMAL_MS, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_FLASH_COUNT, 16'h0001, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b1, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_CFG, CFG_FLASH_LEVEL, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b0, PINS_DARK},
    '{ROW_TICK, '0, 16'h0000, 1'b0, 1'b0, PINS_DARK}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_error_flag = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_red_on;
  logic        out_green_on;
  logic        out_blue_on;
  logic        out_pattern_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predicted block state
  rlpf_cfg_t   cfg_now;
  cnt_t        pwm_phase  [CHANNELS];
  logic [4:0]  led_level  [CHANNELS];
  ptime_t      flash_time [CHANNELS];
  logic [7:0]  flash_cnt  [CHANNELS];
  logic [7:0]  task_div;
  logic        mode_now;
  logic        mode_last;

  rlpf_res_t   expected_pins_q [$];

  // Run control and tallies
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int failures = 0;
  int ticks_sent = 0;
  int cfg_writes = 0;
  int pattern_ends = 0;
  int stalls_seen = 0;

  rgb_led_pwm_flash_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_error_flag    (in_error_flag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red_on       (out_red_on),
    .out_green_on     (out_green_on),
    .out_blue_on      (out_blue_on),
    .out_pattern_done (out_pattern_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Clear the predicted state and load register defaults
  task automatic reset_led_model();
    cfg_now = '{flash_level: RST_FLASH_LEVEL, flash_count: RST_FLASH_COUNT,
                on_time_ms: RST_ON_TIME_MS, off_time_ms: RST_OFF_TIME_MS,
                gap_normal_ms: RST_GAP_NORMAL_MS, gap_error_ms: RST_GAP_ERROR_MS,
                task_period: RST_TASK_PERIOD};
    for (int i = 0; i < CHANNELS; i++) begin
      pwm_phase[i]  = '0;
      led_level[i]  = '0;
      flash_time[i] = '0;
      flash_cnt[i]  = '0;
    end
    task_div  = '0;
    mode_now  = 1'b0;
    mode_last = 1'b0;
  endtask

  // Mirror a register write into the predicted configuration
  task automatic store_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      CFG_FLASH_LEVEL:   cfg_now.flash_level   = data[4:0];
      CFG_FLASH_COUNT:   cfg_now.flash_count   = data[7:0];
      CFG_ON_TIME_MS:    cfg_now.on_time_ms    = data;
      CFG_OFF_TIME_MS:   cfg_now.off_time_ms   = data;
      CFG_GAP_NORMAL_MS: cfg_now.gap_normal_ms = data;
      CFG_GAP_ERROR_MS:  cfg_now.gap_error_ms  = data;
      CFG_TASK_PERIOD:   cfg_now.task_period   = data[7:0];
      default: ;
    endcase
  endtask

  // Advance the predicted state by one tick and return the pins it drives
  function automatic rlpf_res_t predict_led_tick(logic flag);
    rlpf_res_t   res;
    logic [2:0]  pins;
    int unsigned step_ms, lvl, t, gap, ch, flash_end;
    res  = '0;
    pins = '0;
    // Pins come from the levels before this tick's task step
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < 3) pins[i] = (pwm_phase[i] < led_level[i]);
      pwm_phase[i] = (pwm_phase[i] > LEVEL_MAX) ? '0 : pwm_phase[i] + 1'b1;
    end
    step_ms = (cfg_now.task_period == 0) ? 1 : cfg_now.task_period;
    if (task_div == 0) begin
      // A mode change seen at the previous step clears every pattern
      if (mode_now != mode_last) begin
        mode_last = mode_now;
        for (int i = 0; i < CHANNELS; i++) begin
          led_level[i]  = '0;
          flash_time[i] = '0;
          flash_cnt[i]  = '0;
        end
      end
      mode_now = flag;
      ch  = mode_now ? CH_RED : CH_GREEN;
      gap = mode_now ? cfg_now.gap_error_ms : cfg_now.gap_normal_ms;
      lvl = (cfg_now.flash_level > LEVEL_MAX) ? LEVEL_MAX : cfg_now.flash_level;
      flash_end = 32'(cfg_now.on_time_ms) + 32'(cfg_now.off_time_ms);
      if (ch < CHANNELS) begin
        t = flash_time[ch];
        if (flash_cnt[ch] < cfg_now.flash_count) begin
          if (t < cfg_now.on_time_ms) begin
            led_level[ch] = 5'(lvl);
          end else if (t < flash_end) begin
            led_level[ch] = '0;
          end else begin
            t = 0;
            flash_cnt[ch] = flash_cnt[ch] + 1'b1;
          end
        end else if (t < gap) begin
          led_level[ch] = '0;
        end else begin
          t = 0;
          flash_cnt[ch] = '0;
          res.pattern_done = 1'b1;
        end
        t = t + step_ms;
        flash_time[ch] = (t > TIME_SAT) ? ptime_t'(TIME_SAT) : ptime_t'(t);
      end
      for (int i = 0; i < CHANNELS; i++)
        if (i != ch) led_level[i] = '0;
    end
    // Wrap the divider, also when the period was lowered below it
    task_div = task_div + 1'b1;
    if (task_div >= step_ms) task_div = '0;
    res.red_on   = pins[0];
    res.green_on = pins[1];
    res.blue_on  = pins[2];
    return res;
  endfunction

  // Pick a register value; upper data bits stay random to exercise masking
  function automatic logic [15:0] pick_reg_value(logic [2:0] idx, int style);
    logic [15:0] v;
    int roll;
    v    = 16'($urandom);
    roll = $urandom_range(99);
    case (idx)
      CFG_FLASH_LEVEL: begin
        if (style == STYLE_MIN) v[4:0] = '0;
        else if (style == STYLE_MAX) v[4:0] = '1;
      end
      CFG_FLASH_COUNT, CFG_TASK_PERIOD: begin
        if (style == STYLE_MIN || roll < 10) v[7:0] = '0;
        else if (style == STYLE_MAX || roll < 15) v[7:0] = '1;
        else v[7:0] = 8'($urandom_range(1, 4));
      end
      default: begin
        if (style == STYLE_MIN || roll < 10) v = '0;
        else if (style == STYLE_MAX || roll < 15) v = '1;
        else v = 16'($urandom_range(0, 24));
      end
    endcase
    return v;
  endfunction

  // Offer one register write and hold it until taken
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, data);
    cfg_writes++;
  endtask

  // Offer one tick, with random idle cycles ahead of it
  task automatic send_tick(logic flag, logic typed, rlpf_res_t typed_res);
    rlpf_res_t pred;
    cfg_valid <= 1'b0;
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_error_flag <= flag;
    do @(posedge clk); while (in_stall);
    pred = predict_led_tick(flag);
    expected_pins_q.push_back(typed ? typed_res : pred);
    ticks_sent++;
  endtask

  // Stop offering and wait until every pending result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pins_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_pin(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      failures++;
    end
  endtask

  // Receiver: random stalls, quiet stretches and one long hold-off
  always @(posedge clk) begin
    if (hold_off_req) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 27);
    end
  end

  // Compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    rlpf_res_t want;
    if (rst_n && in_valid && in_stall) stalls_seen++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pins_q.size() == 0) begin
        $error("result item with no tick pending");
        failures++;
      end else begin
        want = expected_pins_q.pop_front();
        check_pin("red_on", want.red_on, out_red_on);
        check_pin("green_on", want.green_on, out_green_on);
        check_pin("blue_on", want.blue_on, out_blue_on);
        check_pin("pattern_done", want.pattern_done, out_pattern_done);
        if (want.pattern_done) pattern_ends++;
      end
    end
  end

  // Abort when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic flag;
    int   style;
    reset_led_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].data);
      end else begin
        send_tick(DIRECTED_ROWS[r].flag, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
      end
    end

    // Random phases, each with a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      style = (p == 1) ? STYLE_MIN : (p == 2) ? STYLE_MAX : STYLE_RANDOM;
      for (int idx = 0; idx <= CFG_TASK_PERIOD; idx++)
        write_reg(3'(idx), pick_reg_value(3'(idx), style));
      calm = (p == 3);
      flag = 1'($urandom_range(1));
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (p == 4 && n == 20) hold_off_req = 1'b1;
        if (p == 5 && n == 40) wait_drained();
        if ($urandom_range(29) == 0) flag = ~flag;
        send_tick(($urandom_range(19) == 0) ? ~flag : flag, 1'b0, PINS_DARK);
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d ticks over %0d register writes, %0d pattern ends",
             ticks_sent, cfg_writes, pattern_ends);
    $display("input held back in %0d cycles by result back-pressure", stalls_seen);
    if (failures == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
